[rtl/core/tdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg
// shared types, constants and the entry ordering function of the timer
// deadline queue
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int TDQ_DEPTH       = 16;
  localparam int TDQ_MAX_RESULTS = 16;
  localparam int TDQ_NW          = $clog2(TDQ_MAX_RESULTS + 1);
  localparam int TIME_W          = 48;
  localparam int TASK_W          = 16;
  localparam int ORDER_W         = 32;
  localparam int TIMEOUT_W       = 32;
  localparam int KIND_W          = 2;

  typedef enum logic {
    OP_SCHED = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_TK_RD,
    ST_TK_CHK,
    ST_DN_RD,
    ST_DN_CMP,
    ST_TK_FIN
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [ORDER_W-1:0] order;
    logic [TASK_W-1:0]  tid;
  } entry_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [TASK_W-1:0] tid;
    logic              last;
  } emit_t;

  // earlier deadline first, then lower insertion number
  function automatic logic precedes(entry_t a, entry_t b);
    logic [TIME_W+ORDER_W-1:0] ka;
    logic [TIME_W+ORDER_W-1:0] kb;
    ka = {a.deadline, a.order};
    kb = {b.deadline, b.order};
    return ka < kb;
  endfunction

endpackage

[rtl/core/tdq_heap_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_heap_mem
// heap entry store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module tdq_heap_mem
  import tdq_pkg::*;
#(
  parameter int DEPTH = TDQ_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] ra0,
  input  logic [AW-1:0] ra1,
  output entry_t        rd0,
  output entry_t        rd1
);

  entry_t mem [DEPTH];
  entry_t rd0_r;
  entry_t rd1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

[rtl/core/tdq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_ctrl
// time counter and heap sequencer: sift-up on schedule, pop and sift-down
// on tick
// ----------------------------------------------------------------------------
module tdq_ctrl
  import tdq_pkg::*;
#(
  parameter int DEPTH = TDQ_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  op_t                  in_op,
  input  logic [TASK_W-1:0]    in_task,
  input  logic [TIMEOUT_W-1:0] in_timeout,
  output logic                 in_ready,
  input  logic                 out_free,
  output emit_t                emit,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output entry_t               mem_wdata,
  output logic [AW-1:0]        mem_ra0,
  output logic [AW-1:0]        mem_ra1,
  input  entry_t               mem_rd0,
  input  entry_t               mem_rd1
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 1;

  state_t              state_r, state_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [ORDER_W-1:0]  ictr_r, ictr_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  entry_t              key_r, key_nxt;
  logic [TDQ_NW-1:0]   n_r, n_nxt;
  logic                pend_r, pend_nxt;
  logic [TASK_W-1:0]   pend_task_r, pend_task_nxt;

  logic                acc;
  logic                full;
  logic [CW-1:0]       cnt_m1;
  logic [AW-1:0]       last_addr;
  logic [AW-1:0]       par_idx;
  logic [IW-1:0]       cnt_w;
  logic [IW-1:0]       c1;
  logic [IW-1:0]       c2;
  logic                has_kids;
  logic                c2_ok;
  logic                due;
  logic                sel_right;
  entry_t              sel;
  logic [AW-1:0]       sel_idx;
  logic                up_swap;
  logic                dn_swap;
  logic [TIME_W:0]     dl_sum;
  logic [TIME_W-1:0]   dl_sat;
  logic [TIME_W-1:0]   now_inc;
  logic                pend_stall;

  assign in_ready   = (state_r == ST_IDLE) && out_free;
  assign acc        = in_valid && in_ready;
  assign full       = (count_r == CW'(DEPTH));
  assign cnt_m1     = count_r - CW'(1);
  assign last_addr  = cnt_m1[AW-1:0];
  assign par_idx    = (idx_r - AW'(1)) >> 1;
  assign cnt_w      = IW'(count_r);
  assign c1         = (IW'(idx_r) << 1) | IW'(1);
  assign c2         = c1 + IW'(1);
  assign has_kids   = c1 < cnt_w;
  assign c2_ok      = c2 < cnt_w;
  assign due        = mem_rd0.deadline <= now_r;
  assign sel_right  = c2_ok && precedes(mem_rd1, mem_rd0);
  assign sel        = sel_right ? mem_rd1 : mem_rd0;
  assign sel_idx    = sel_right ? c2[AW-1:0] : c1[AW-1:0];
  assign up_swap    = precedes(key_r, mem_rd0);
  assign dn_swap    = precedes(sel, key_r);
  assign dl_sum     = {1'b0, now_r} + (TIME_W+1)'(in_timeout);
  assign dl_sat     = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
  assign now_inc    = (now_r == {TIME_W{1'b1}}) ? now_r : now_r + TIME_W'(1);
  assign pend_stall = pend_r && !out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_op == OP_TICK) begin
            state_nxt = ST_TK_RD;
          end else if (!full) begin
            state_nxt = ST_UP_RD;
          end
        end
      end
      ST_UP_RD: begin
        state_nxt = (idx_r == '0) ? ST_IDLE : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_nxt = up_swap ? ST_UP_RD : ST_IDLE;
      end
      ST_TK_RD: begin
        if (count_r == '0 || n_r == TDQ_NW'(TDQ_MAX_RESULTS)) begin
          state_nxt = ST_TK_FIN;
        end else begin
          state_nxt = ST_TK_CHK;
        end
      end
      ST_TK_CHK: begin
        if (!due) begin
          state_nxt = ST_TK_FIN;
        end else if (pend_stall) begin
          state_nxt = ST_TK_CHK;
        end else if (count_r == CW'(1)) begin
          state_nxt = ST_TK_RD;
        end else begin
          state_nxt = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        state_nxt = has_kids ? ST_DN_CMP : ST_TK_RD;
      end
      ST_DN_CMP: begin
        state_nxt = dn_swap ? ST_DN_RD : ST_TK_RD;
      end
      ST_TK_FIN: begin
        state_nxt = pend_stall ? ST_TK_FIN : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath, memory ports and results
  always_comb begin
    now_nxt       = now_r;
    count_nxt     = count_r;
    ictr_nxt      = ictr_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    pend_task_nxt = pend_task_r;
    emit          = '0;
    emit.kind     = KIND_FIRED;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = key_r;
    mem_ra0       = '0;
    mem_ra1       = last_addr;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_op == OP_TICK) begin
            now_nxt  = now_inc;
            n_nxt    = '0;
            pend_nxt = 1'b0;
          end else begin
            emit.valid = 1'b1;
            emit.kind  = full ? KIND_FULL : KIND_SCHED;
            emit.tid   = in_task;
            emit.last  = 1'b1;
            if (!full) begin
              key_nxt.deadline = dl_sat;
              key_nxt.order    = ictr_r;
              key_nxt.tid      = in_task;
              idx_nxt          = count_r[AW-1:0];
              count_nxt        = count_r + CW'(1);
              ictr_nxt         = ictr_r + ORDER_W'(1);
            end
          end
        end
      end
      ST_UP_RD: begin
        mem_ra0 = par_idx;
        if (idx_r == '0) begin
          mem_we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        mem_ra0 = par_idx;
        mem_we  = 1'b1;
        if (up_swap) begin
          mem_wdata = mem_rd0;
          idx_nxt   = par_idx;
        end
      end
      ST_TK_RD: begin
        mem_ra0 = '0;
      end
      ST_TK_CHK: begin
        mem_ra0 = '0;
        if (due && !pend_stall) begin
          if (pend_r) begin
            emit.valid = 1'b1;
            emit.tid   = pend_task_r;
          end
          pend_nxt      = 1'b1;
          pend_task_nxt = mem_rd0.tid;
          n_nxt         = n_r + TDQ_NW'(1);
          count_nxt     = cnt_m1;
          key_nxt       = mem_rd1;
          idx_nxt       = '0;
        end
      end
      ST_DN_RD: begin
        mem_ra0 = c1[AW-1:0];
        mem_ra1 = c2[AW-1:0];
        if (!has_kids) begin
          mem_we = 1'b1;
        end
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (dn_swap) begin
          mem_wdata = sel;
          idx_nxt   = sel_idx;
        end
      end
      ST_TK_FIN: begin
        if (pend_r && out_free) begin
          emit.valid = 1'b1;
          emit.tid   = pend_task_r;
          emit.last  = 1'b1;
          pend_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      now_r   <= '0;
      count_r <= '0;
      ictr_r  <= '0;
      n_r     <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      count_r <= count_nxt;
      ictr_r  <= ictr_nxt;
      n_r     <= n_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    pend_task_r <= pend_task_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above store depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result issued while output register busy");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_r)
    else $error("request taken with a fired result still held");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_SCHED && full) |=> $stable(count_r) && state_r == ST_IDLE)
    else $error("dropped schedule changed the store");

  a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= TDQ_NW'(TDQ_MAX_RESULTS))
    else $error("too many timeouts fired on one tick");
`endif

endmodule

[rtl/core/timer_deadline_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_queue
// millisecond time counter with a min-heap of pending task timeouts
// ----------------------------------------------------------------------------
// A schedule request (in_tuser = 0) stores deadline = now + timeout,
// saturated at the 48-bit top, and answers at once with one result: kind
// scheduled, or queue full when DEPTH entries are pending (the request is
// then dropped and the block stays idle). The entry is then sifted up a
// binary heap held in a synchronous memory, each level walked taking a
// parent read and a compare step, and the block takes no new request until
// the sift-up ends. A tick request (in_tuser = 1) bumps the time counter
// (saturating) and pops every entry whose deadline is at or before the new
// time, earliest deadline first and equal deadlines in insertion order, at
// most 16 per tick; the last result of the run carries out_tlast. Each pop
// reads and checks the root, then sifts the last entry down the heap, each
// level reading both children through the heap memory's two read ports and
// then comparing them. A tick ends with a closing step that issues the last
// held result, if any, and the block takes no new request until it ends;
// back-pressure on the result side can stall the pops and the closing step.
// One result is held in the output register while the sequencer goes on.
// The heap store has no reset and needs no clearing pass: only the first
// entry-count slots are ever used.
// ----------------------------------------------------------------------------
module timer_deadline_queue
  import tdq_pkg::*;
#(
  parameter int DEPTH = TDQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] task_id, [47:16] timeout
  input  logic        in_tuser,   // [0] op: 0 schedule, 1 tick
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] task_id
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last result of the request
);

  localparam int AW = $clog2(DEPTH);

  // sequencer to output stage
  emit_t              emit;
  logic               out_free;

  // heap memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic [AW-1:0]      mem_ra0;
  logic [AW-1:0]      mem_ra1;
  entry_t             mem_rd0;
  entry_t             mem_rd1;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0]  out_task_r;
  kind_t              out_kind_r;
  logic               out_last_r;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;

  tdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_op      (op_t'(in_tuser)),
    .in_task    (in_tdata[15:0]),
    .in_timeout (in_tdata[47:16]),
    .in_ready   (in_tready),
    .out_free   (out_free),
    .emit       (emit),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_ra0    (mem_ra0),
    .mem_ra1    (mem_ra1),
    .mem_rd0    (mem_rd0),
    .mem_rd1    (mem_rd1)
  );

  tdq_heap_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_heap_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .ra0   (mem_ra0),
    .ra1   (mem_ra1),
    .rd0   (mem_rd0),
    .rd1   (mem_rd1)
  );

  // load on a new result, clear once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_task_r <= emit.tid;
      out_kind_r <= emit.kind;
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_task_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
